/* src/base85_guid_decoder_core_defines.svh */
// Assertion macros shared by the base85 GUID decoder RTL.
// Depends on nothing; include it before the module that asserts.
`ifndef BASE85_GUID_DECODER_CORE_DEFINES_SVH
`define BASE85_GUID_DECODER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define B85G_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define B85G_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/b85g_pkg.sv */
// Package for the base85 GUID decoder: widths, the digit and weight tables,
// and the beat types that pass between the front end, the back end and the queues.
package b85g_pkg;

   localparam int CHARS_PER_FRAME_DEF = 20;
   localparam int POS_W    = 7;   // holds a frame position up to 127
   localparam int SLOT_W   = 3;   // digit position within a word, 0 to 4
   localparam int DIGIT_W  = 7;   // a base85 digit, 0 to 84
   localparam int WEIGHT_W = 26;  // 85^4 fits in 26 bits
   localparam int PROD_W   = DIGIT_W + WEIGHT_W;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(4);
   localparam logic [7:0]        NO_DIGIT  = 8'hff;

   localparam logic [7:0] DIGIT_TABLE [128] = '{
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
      8'hff,8'h00,8'hff,8'hff,8'h01,8'h02,8'h03,8'h04,
      8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'hff,
      8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,
      8'h14,8'h15,8'hff,8'hff,8'hff,8'h16,8'hff,8'h17,
      8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'h1e,8'h1f,
      8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,
      8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'h2e,8'h2f,
      8'h30,8'h31,8'h32,8'h33,8'hff,8'h34,8'h35,8'h36,
      8'h37,8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,
      8'h3f,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,
      8'h47,8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,
      8'h4f,8'h50,8'h51,8'h52,8'hff,8'h53,8'h54,8'hff
   };

   // Place value of a digit within its word, least significant digit first.
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [SLOT_W-1:0] slot);
      logic [WEIGHT_W-1:0] w;
      unique case (slot)
         3'd0:    w = WEIGHT_W'(1);
         3'd1:    w = WEIGHT_W'(85);
         3'd2:    w = WEIGHT_W'(7225);
         3'd3:    w = WEIGHT_W'(614125);
         3'd4:    w = WEIGHT_W'(52200625);
         default: w = '0;
      endcase
      return w;
   endfunction

   // A classified character as handed from the front end to the back end.
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [SLOT_W-1:0]  slot;
      logic [INDEX_W-1:0] word_index;
      logic               bad;
      logic               emit;
      logic               last;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic [WORD_W-1:0]  word_value;
      logic [INDEX_W-1:0] word_index;
      logic               bad_char;
      logic               frame_last;
   } result_type;

endpackage

/* src/b85g_fifo.sv */
// Small first-in first-out queue of flip-flops with a push/full and pop/empty interface.
// Depends on nothing; used for the item queue and the result queue of the decoder.
module b85g_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/b85g_front.sv */
// Front end of the decoder: digit lookup, frame position tracking, classification.
// Depends on b85g_pkg and the assertion macros.
`include "base85_guid_decoder_core_defines.svh"
module b85g_front
   import b85g_pkg::*;
#(
   parameter int CHARS_PER_FRAME = CHARS_PER_FRAME_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   output item_type   item
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [INDEX_W-1:0] word_ff, word_in;
   logic [7:0]         entry;
   logic               bad, frame_end;

   assign entry     = DIGIT_TABLE[char_code[6:0]];
   assign bad       = char_code[7] || (entry == NO_DIGIT);
   assign frame_end = (pos_ff == POS_W'(CHARS_PER_FRAME - 1));

   always_comb begin
      item.digit      = entry[DIGIT_W-1:0];
      item.slot       = slot_ff;
      item.word_index = word_ff;
      item.bad        = bad;
      item.emit       = bad || frame_end || (slot_ff == LAST_SLOT);
      item.last       = bad || frame_end;
   end

   // Position counters restart after an aborted frame and at the end of every frame.
   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      word_in = word_ff;
      if (accept) begin
         if (bad || frame_end) begin
            pos_in  = '0;
            slot_in = '0;
            word_in = '0;
         end else begin
            pos_in = POS_W'(pos_ff + 1'b1);
            if (slot_ff == LAST_SLOT) begin
               slot_in = '0;
               word_in = INDEX_W'(word_ff + 1'b1);
            end else begin
               slot_in = SLOT_W'(slot_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         slot_ff <= '0;
         word_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         slot_ff <= slot_in;
         word_ff <= word_in;
      end
   end

   `B85G_ASSERT_ALWAYS(a_pos_in_frame, clock, reset, pos_ff < POS_W'(CHARS_PER_FRAME), "frame position ran past the frame")
   `B85G_ASSERT_ALWAYS(a_slot_range, clock, reset, slot_ff <= LAST_SLOT, "digit slot out of range")
   `B85G_ASSERT_NEXT(a_abort_restart, clock, reset, accept && bad, (pos_ff == '0) && (slot_ff == '0) && (word_ff == '0), "frame did not restart after a bad character")

endmodule

/* src/b85g_back.sv */
// Back end of the decoder: multiplies each digit by its place value and accumulates words.
// Depends on b85g_pkg and the assertion macros.
`include "base85_guid_decoder_core_defines.svh"
module b85g_back
   import b85g_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   input  logic       result_full,
   output logic       result_push,
   output result_type result
);

   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] product;
   logic [WORD_W-1:0] base, sum;

   assign item_pop    = item_valid && !result_full;
   assign result_push = item_pop && item.emit;

   assign product = PROD_W'(item.digit) * PROD_W'(weight_of(item.slot));
   assign base    = (item.slot == '0) ? '0 : acc_ff;
   assign sum     = base + product[WORD_W-1:0];

   always_comb begin
      result.word_value = item.bad ? '0 : sum;
      result.word_index = item.word_index;
      result.bad_char   = item.bad;
      result.frame_last = item.last;
   end

   always_comb begin
      acc_in = acc_ff;
      if (item_pop) begin
         acc_in = item.emit ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   `B85G_ASSERT_NEXT(a_acc_cleared, clock, reset, item_pop && item.emit, acc_ff == '0, "accumulator not cleared after a word was sent")

endmodule

/* src/base85_guid_decoder_core.sv */
// Top level of the base85 GUID decoder: front end, item queue, back end, result queue.
// Depends on b85g_pkg, b85g_fifo, b85g_front and b85g_back.
//
// Usage. Characters arrive one byte per beat on the request side: a beat is taken at a
// rising edge where req_push is high and req_full is low. Each byte is a base85 digit;
// five digits make a 32-bit word, least significant digit first, and CHARS_PER_FRAME
// characters make a frame (twenty characters, four words, one GUID by default).
// A result beat appears on the response side for every completed word, with its index
// in the frame; the final word is flagged as last. A byte outside the alphabet yields a
// result with bad_char and frame_last set and a zero word, and the next byte opens a
// new frame. A result is held on the rsp_ ports while rsp_empty is low and is taken at
// an edge where rsp_pop is high.
// Throughput is one character per cycle while req_full is low; the single digit
// multiply-accumulate in the back end sets that figure. The character that completes
// a word is registered in the item queue, the back end writes the word into the
// result queue, and from then on it shows on the response ports when nothing older waits.
// Reset clears the frame position, the accumulator and both queues.
// When the receiver stalls, the result queue fills, the back end stops, and then the
// item queue fills and req_full rises; nothing is dropped.
module base85_guid_decoder_core
   import b85g_pkg::*;
#(
   parameter int CHARS_PER_FRAME = CHARS_PER_FRAME_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_char_code,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [WORD_W-1:0]   rsp_word_value,
   output logic [INDEX_W-1:0]  rsp_word_index,
   output logic                rsp_bad_char,
   output logic                rsp_frame_last
);

   // The item queue decouples classification from the arithmetic, so the front end
   // keeps taking characters while the back end waits on a full result queue.
   logic       accept;
   item_type   front_item, back_item;
   logic       item_empty, item_pop;
   logic       result_full, result_push;
   result_type back_result, out_result;

   assign accept = req_push && !req_full;

   b85g_front #(
      .CHARS_PER_FRAME(CHARS_PER_FRAME)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .item      (front_item)
   );

   b85g_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_item),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   b85g_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (!item_empty),
      .item        (back_item),
      .item_pop    (item_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   // The result queue lets the back end finish a word while the previous one waits.
   b85g_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (out_result),
      .empty     (rsp_empty)
   );

   assign rsp_word_value = out_result.word_value;
   assign rsp_word_index = out_result.word_index;
   assign rsp_bad_char   = out_result.bad_char;
   assign rsp_frame_last = out_result.frame_last;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for base85_guid_decoder_core: directed and random character beats,
// each result beat checked against a local decoder model kept in step with accepted beats.
// Depends on b85g_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;
   import b85g_pkg::*;

   // The frame length given to the block. The model below follows any legal value,
   // so the partial-word and index-wrap cases come into play if this is changed.
   localparam int FRAME_CHARS   = CHARS_PER_FRAME_DEF;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LIMIT  = 10;

   // One decoded result as the response side should present it.
   typedef struct packed {
      logic [WORD_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      logic               bad;
      logic               last;
   } decoded_word_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_push      = 1'b0;
   logic [7:0]          req_char_code = 8'h00;
   logic                rsp_pop       = 1'b0;
   logic                req_full;
   logic                rsp_empty;
   logic [WORD_W-1:0]   rsp_word_value;
   logic [INDEX_W-1:0]  rsp_word_index;
   logic                rsp_bad_char;
   logic                rsp_frame_last;

   // Words that the model has predicted and the block has not yet delivered, oldest first.
   decoded_word_type pending_words[$];

   // Model state: position within the frame and the partially built word.
   int unsigned       frame_pos = 0;
   logic [WORD_W-1:0] word_acc  = '0;

   int  fail_count     = 0;
   int  sent_count     = 0;
   int  cycle_count    = 0;
   bit  idling_on      = 1'b1;
   bit  sender_gaps_on = 1'b1;
   int  stall_left     = 0;
   int  quiet_left     = 0;

   base85_guid_decoder_core #(
      .CHARS_PER_FRAME (FRAME_CHARS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_word_value (rsp_word_value),
      .rsp_word_index (rsp_word_index),
      .rsp_bad_char   (rsp_bad_char),
      .rsp_frame_last (rsp_frame_last)
   );

   always #10 clock = ~clock;

   // Watchdog. A correct run finishes far inside this limit, even with every beat
   // delayed by the longest sender gap and every result held by the longest stall.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The alphabet, written out by ranges of printable ASCII rather than as a lookup,
   // so that the model does not share the block's digit table. Returns 0 for a byte
   // that is not a base85 digit, including every byte of 0x80 and above.
   function automatic bit decode_digit(input logic [7:0] ch, output logic [DIGIT_W-1:0] digit);
      bit ok;
      ok    = 1'b1;
      digit = '0;
      if (ch == 8'h21)                      digit = DIGIT_W'(0);
      else if (ch >= 8'h24 && ch <= 8'h2e)  digit = DIGIT_W'(ch - 8'h23);
      else if (ch >= 8'h30 && ch <= 8'h39)  digit = DIGIT_W'(ch - 8'h24);
      else if (ch == 8'h3d)                 digit = DIGIT_W'(22);
      else if (ch == 8'h3f)                 digit = DIGIT_W'(23);
      else if (ch >= 8'h40 && ch <= 8'h5b)  digit = DIGIT_W'(ch - 8'h28);
      else if (ch >= 8'h5d && ch <= 8'h7b)  digit = DIGIT_W'(ch - 8'h29);
      else if (ch == 8'h7d)                 digit = DIGIT_W'(83);
      else if (ch == 8'h7e)                 digit = DIGIT_W'(84);
      else                                  ok = 1'b0;
      return ok;
   endfunction

   // Place value of the digit in a given slot: 85 to the power of the slot.
   function automatic logic [WORD_W-1:0] place_value(input int unsigned slot);
      logic [WORD_W-1:0] w;
      w = WORD_W'(1);
      for (int i = 0; i < slot; i++) w = WORD_W'(w * WORD_W'(85));
      return w;
   endfunction

   // Advance the model by one accepted character and queue the word it completes, if any.
   // An invalid byte aborts the frame with a zero word flagged bad and last. The final
   // character of a frame flushes whatever digits the word holds, even a partial word.
   task automatic predict_decoded_word(input logic [7:0] ch);
      int unsigned        pos;
      int unsigned        slot;
      logic [DIGIT_W-1:0] digit;
      logic [WORD_W-1:0]  acc;
      bit                 frame_end;
      decoded_word_type   w;
      pos  = (frame_pos >= FRAME_CHARS) ? 0 : frame_pos;
      slot = pos % 5;
      w.index = INDEX_W'(pos / 5);
      if (!decode_digit(ch, digit)) begin
         w.value = '0;
         w.bad   = 1'b1;
         w.last  = 1'b1;
         pending_words.push_back(w);
         frame_pos = 0;
         word_acc  = '0;
      end else begin
         acc       = (slot == 0) ? '0 : word_acc;
         acc       = acc + WORD_W'(digit) * place_value(slot);
         frame_end = (pos + 1 >= FRAME_CHARS);
         if (slot == 4 || frame_end) begin
            w.value = acc;
            w.bad   = 1'b0;
            w.last  = frame_end;
            pending_words.push_back(w);
            word_acc  = '0;
            frame_pos = frame_end ? 0 : pos + 1;
         end else begin
            word_acc  = acc;
            frame_pos = pos + 1;
         end
      end
   endtask

   // Offer one character beat, after an occasional random gap, and hold it until the
   // block takes it. The model is advanced at the very edge that accepts the beat.
   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= ch;
      do @(posedge clock); while (req_full);
      predict_decoded_word(ch);
      sent_count++;
   endtask

   // Stop sending and wait until every predicted word has been delivered. The push line
   // stays low for the whole wait, before the sender may raise it again.
   task automatic pause_until_decoded();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // A random valid character, with the smallest and largest digits favoured a little.
   function automatic logic [7:0] random_valid_char();
      logic [7:0]         ch;
      logic [DIGIT_W-1:0] digit;
      case ($urandom_range(0, 9))
         0:       ch = 8'h21;
         1:       ch = 8'h7e;
         default: begin
            do ch = 8'($urandom_range(8'h21, 8'h7e)); while (!decode_digit(ch, digit));
         end
      endcase
      return ch;
   endfunction

   // A random invalid character: either a high byte or one of the holes below 0x80.
   function automatic logic [7:0] random_invalid_char();
      logic [7:0]         ch;
      logic [DIGIT_W-1:0] digit;
      if ($urandom_range(0, 1) == 0) begin
         ch = 8'($urandom_range(8'h80, 8'hff));
      end else begin
         do ch = 8'($urandom_range(8'h00, 8'h7f)); while (decode_digit(ch, digit));
      end
      return ch;
   endfunction

   // One whole frame of extremes: the largest word (which wraps past 2^32), a zero
   // word, and words built from characters at or near the ends of the alphabet ranges.
   task automatic test_directed_frame();
      logic [7:0] chars[20];
      chars = '{8'h7e, 8'h7e, 8'h7e, 8'h7e, 8'h7e,
                8'h21, 8'h21, 8'h21, 8'h21, 8'h21,
                8'h21, 8'h24, 8'h30, 8'h7a, 8'h7d,
                8'h7d, 8'h3d, 8'h3f, 8'h5b, 8'h5d};
      for (int i = 0; i < FRAME_CHARS; i++) send_char(chars[i % 20]);
   endtask

   // Invalid characters in different places: a hole in the alphabet at the start of a
   // frame, the top hole below 0x80, and a high byte that aborts the second word.
   task automatic test_directed_errors();
      send_char(8'h22);
      send_char(8'h7f);
      repeat (5) send_char(8'h7e);
      send_char(8'h80);
   endtask

   // Random traffic until the given number of beats has been sent. Most of it is
   // well-formed frames with random digits, so that every word index and the frame end
   // are reached often; the rest is frames cut short by a bad byte, and raw noise.
   task automatic test_random_frames(input int beat_target);
      int kind;
      int n;
      while (sent_count < beat_target) begin
         sender_gaps_on = idling_on && ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            // Finish the frame in progress, or send a whole one if at a frame boundary.
            n = FRAME_CHARS - int'(frame_pos);
            repeat (n) send_char(random_valid_char());
         end else if (kind < 18) begin
            n = $urandom_range(0, FRAME_CHARS - 1);
            repeat (n) send_char(random_valid_char());
            send_char(random_invalid_char());
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) send_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // The sender stops mid-run until the block has emptied, then carries on.
   task automatic test_drain_pause(input int beat_target);
      test_random_frames(beat_target);
      pause_until_decoded();
      test_random_frames(beat_target + 40);
   endtask

   // A closing stretch at full rate on both sides, with no idling at all.
   task automatic test_steady_stream(input int beat_target);
      idling_on = 1'b0;
      test_random_frames(beat_target);
   endtask

   // Response side. The result on the ports is taken at an edge where pop is high and
   // empty is low; both are sampled as they stood before the edge. Pop is then set for
   // the next cycle, with random stalls and quiet stretches without stalls between.
   always @(posedge clock) begin
      decoded_word_type got;
      decoded_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_word_value, rsp_word_index, rsp_bad_char, rsp_frame_last};
         if (pending_words.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("cycle %0d: result beat with nothing pending: value %h index %0d bad %b last %b",
                        cycle_count, got.value, got.index, got.bad, got.last);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("cycle %0d: mismatch: expected value %h index %0d bad %b last %b, %s",
                           cycle_count, want.value, want.index, want.bad, want.last,
                           $sformatf("actual value %h index %0d bad %b last %b",
                                     got.value, got.index, got.bad, got.last));
            end
         end
      end
      if (stall_left != 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else if (idling_on && quiet_left == 0 && $urandom_range(0, 7) == 0) begin
         rsp_pop <= 1'b0;
         stall_left = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) quiet_left = $urandom_range(20, 80);
      end else begin
         rsp_pop <= 1'b1;
         if (quiet_left != 0) quiet_left--;
      end
   end

   // Test sequence. Reset is held and released once; the directed beats come first,
   // then random traffic with idling on both sides, a full drain in the middle, and a
   // last stretch without idling. At the end the bench waits for every predicted word,
   // then waits out SETTLE_CYCLES to catch any stray result beat, and reports.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frame();
      test_directed_errors();
      test_drain_pause(700);
      test_random_frames(1100);
      test_steady_stream(1400);
      pause_until_decoded();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
